// ----- src/d8pp_pkg.sv -----
// Package for the D8 pour point selector: widths, reset values, direction step tables
// and the types shared by the cell chain and the top level.
// No dependencies.
package d8pp_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int MAX_DIM_DEF    = 4096;

	localparam int FLOW_W   = 32;
	localparam int DIR_W    = 4;
	localparam int COORD_W  = 12;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int NPTS_W   = 5;

	localparam int DIM_RESET  = 4096;
	localparam int NPTS_RESET = 16;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_N_POINTS   = 2'd2
	} cfg_reg_t;

	// D8 steps, indexed by direction code: E, SE, S, SW, W, NW, N, NE
	localparam logic signed [1:0] STEP_DX [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
		-2'sd1, -2'sd1, 2'sd0, 2'sd1};
	localparam logic signed [1:0] STEP_DY [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
		2'sd0, -2'sd1, -2'sd1, -2'sd1};

	typedef struct packed {
		logic [FLOW_W-1:0]  flow;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} entry_t;

	// chain commands, at most one active per cycle
	typedef struct packed {
		logic ins;   // insert, list grows
		logic rep;   // drop smallest, insert
		logic pop;   // shift towards cell 0 for output
	} chain_op_t;

endpackage

// ----- src/d8pp_cell.sv -----
// One slot of the sorted pour point chain: holds an entry and its valid bit, compares
// its flow with the newcomer and takes data from either neighbour.
// Depends on d8pp_pkg.
module d8pp_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  d8pp_pkg::chain_op_t op,
	input  d8pp_pkg::entry_t   new_ent,
	input  d8pp_pkg::entry_t   ent_b,   // neighbour towards smaller flow
	input  logic               le_b,
	input  logic               vld_b,
	input  d8pp_pkg::entry_t   ent_a,   // neighbour towards larger flow
	input  logic               le_a,
	input  logic               vld_a,
	output d8pp_pkg::entry_t   ent,
	output logic               le,
	output logic               vld
);

	d8pp_pkg::entry_t ent_q, ent_d;
	logic             vld_q, vld_d;

	assign ent = ent_q;
	assign vld = vld_q;
	assign le  = vld_q && (ent_q.flow <= new_ent.flow);

	always_comb begin
		ent_d = ent_q;
		vld_d = vld_q;
		if (op.pop) begin
			ent_d = ent_a;
			vld_d = vld_a;
		end else if (op.ins) begin
			// slots above the insertion point move up by one
			if (!le) begin
				vld_d = vld_q | vld_b;
				ent_d = le_b ? new_ent : ent_b;
			end
		end else if (op.rep) begin
			// slots below the insertion point move down, slot 0 drops out
			if (le_a) begin
				ent_d = ent_a;
			end else if (le) begin
				ent_d = new_ent;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

endmodule

// ----- src/d8_pour_point_top_n.sv -----
// Top level of the D8 pour point selector: raster position counters, pour point test,
// configuration registers, output control and the chain of sorted cells.
// Depends on d8pp_pkg and d8pp_cell.
//
// Usage: cells of a raster frame arrive in raster order on the s_ channel, one
// transaction per cell; the block counts column and row itself. Pour points (no
// direction, or a direction that leaves the map) are offered to a sorted chain of
// MAX_POINTS cells that keeps the n_points largest flows, ascending, ties in arrival
// order. A frame streams at one cell a clock while s_tready is high.
// On the frame's last cell the chain is updated in that cycle; from the next cycle
// the kept points leave on the m_ channel from cell 0, one per cycle while m_tready
// is high, the final one with m_tlast. s_tready is low during this output phase, until
// the final point is taken; with no point kept the next frame starts at once. A stall
// on m_ holds the current point.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at the next edge and
// are to be made between frames. Reset clears the counters and the chain's valid bits
// and restores width 4096, height 4096, n_points 16.
module d8_pour_point_top_n #(
	parameter int MAX_POINTS = d8pp_pkg::MAX_POINTS_DEF,
	parameter int MAX_DIM    = d8pp_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [d8pp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [d8pp_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: [3:0] flow_dir, [35:4] flow_value, [39:36] zero
	input  logic [d8pp_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: [11:0] point_x, [23:12] point_y
	output logic [d8pp_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int KW = $clog2(MAX_POINTS + 1);
	localparam int DIM_RST_EFF = (d8pp_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM
		: d8pp_pkg::DIM_RESET;
	localparam int NPTS_RST_EFF = (d8pp_pkg::NPTS_RESET > MAX_POINTS) ? MAX_POINTS
		: d8pp_pkg::NPTS_RESET;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   wm1_q, hm1_q;
	logic [KW-1:0]   lim_q;
	logic [CW-1:0]   x_q, y_q;
	logic [KW-1:0]   cnt_q;

	// configuration: store clamped extent minus one and the saturated point count
	logic [31:0]     dim_eff;
	logic [KW-1:0]   lim_d;

	always_comb begin
		if (cfg_data == '0) begin
			dim_eff = 32'd1;
		end else if (32'(cfg_data) > 32'(MAX_DIM)) begin
			dim_eff = 32'(MAX_DIM);
		end else begin
			dim_eff = 32'(cfg_data);
		end
		if (32'(cfg_data[d8pp_pkg::NPTS_W-1:0]) > 32'(MAX_POINTS)) begin
			lim_d = KW'(MAX_POINTS);
		end else begin
			lim_d = KW'(cfg_data[d8pp_pkg::NPTS_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= CW'(DIM_RST_EFF - 1);
			hm1_q <= CW'(DIM_RST_EFF - 1);
			lim_q <= KW'(NPTS_RST_EFF);
		end else if (cfg_we) begin
			case (cfg_idx)
				d8pp_pkg::REG_MAP_WIDTH: begin
					wm1_q <= CW'(dim_eff - 32'd1);
				end
				d8pp_pkg::REG_MAP_HEIGHT: begin
					hm1_q <= CW'(dim_eff - 32'd1);
				end
				d8pp_pkg::REG_N_POINTS: begin
					lim_q <= lim_d;
				end
				default: begin
				end
			endcase
		end
	end

	// input decode and pour point test
	logic [d8pp_pkg::DIR_W-1:0]  dir;
	logic [d8pp_pkg::FLOW_W-1:0] flow;
	logic signed [1:0]           dx, dy;
	logic                        x_end, y_end, pour, row_end, frame_end;
	logic                        x_past, x_far, y_past, y_far;
	logic                        s_acc, m_acc;

	assign dir  = s_tdata[d8pp_pkg::DIR_W-1:0];
	assign flow = s_tdata[d8pp_pkg::DIR_W +: d8pp_pkg::FLOW_W];
	assign dx   = d8pp_pkg::STEP_DX[dir[2:0]];
	assign dy   = d8pp_pkg::STEP_DY[dir[2:0]];
	assign x_end = x_q >= wm1_q;
	assign y_end = y_q >= hm1_q;
	// counters may sit beyond a geometry lowered mid-frame
	assign x_past = x_q > wm1_q;
	assign x_far  = x_past && ((x_q - wm1_q) != CW'(1));
	assign y_past = y_q > hm1_q;
	assign y_far  = y_past && ((y_q - hm1_q) != CW'(1));

	always_comb begin
		if (dir[d8pp_pkg::DIR_W-1]) begin
			pour = 1'b1;   // negative code: no direction
		end else begin
			pour = (dx < 0 && (x_q == '0 || x_far)) || (dx == 0 && x_past)
				|| (dx > 0 && x_end)
				|| (dy < 0 && (y_q == '0 || y_far)) || (dy == 0 && y_past)
				|| (dy > 0 && y_end);
		end
	end

	assign row_end   = x_end;
	assign frame_end = x_end && y_end;

	assign s_tready = (state_q == ST_RUN);
	assign m_tvalid = (state_q == ST_EMIT);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;

	// chain commands
	d8pp_pkg::chain_op_t op;
	d8pp_pkg::entry_t    new_ent;
	d8pp_pkg::entry_t    ent [MAX_POINTS];
	logic                le  [MAX_POINTS];
	logic                vld [MAX_POINTS];
	logic                full;

	assign full = (cnt_q >= lim_q);
	assign new_ent.flow = flow;
	assign new_ent.col  = d8pp_pkg::COORD_W'(x_q);
	assign new_ent.row  = d8pp_pkg::COORD_W'(y_q);
	assign op.ins = s_acc && pour && !full;
	// a full list only takes a flow strictly above its smallest entry
	assign op.rep = s_acc && pour && full && (lim_q != '0) && le[0]
		&& (ent[0].flow != flow);
	assign op.pop = m_acc;

	for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
		d8pp_pkg::entry_t ent_b, ent_a;
		logic             le_b, vld_b, le_a, vld_a;

		if (gi == 0) begin : g_lo
			assign ent_b = new_ent;
			assign le_b  = 1'b1;
			assign vld_b = 1'b1;
		end else begin : g_mid_lo
			assign ent_b = ent[gi-1];
			assign le_b  = le[gi-1];
			assign vld_b = vld[gi-1];
		end
		if (gi == MAX_POINTS - 1) begin : g_hi
			assign ent_a = new_ent;
			assign le_a  = 1'b0;
			assign vld_a = 1'b0;
		end else begin : g_mid_hi
			assign ent_a = ent[gi+1];
			assign le_a  = le[gi+1];
			assign vld_a = vld[gi+1];
		end

		d8pp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.new_ent (new_ent),
			.ent_b   (ent_b),
			.le_b    (le_b),
			.vld_b   (vld_b),
			.ent_a   (ent_a),
			.le_a    (le_a),
			.vld_a   (vld_a),
			.ent     (ent[gi]),
			.le      (le[gi]),
			.vld     (vld[gi])
		);
	end

	assign m_tdata = {ent[0].row, ent[0].col};
	assign m_tlast = (cnt_q == KW'(1));

	// position counters, fill count and phase
	logic [KW-1:0] cnt_ins;
	assign cnt_ins = cnt_q + KW'(op.ins);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			cnt_q   <= '0;
			state_q <= ST_RUN;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (s_acc) begin
						cnt_q <= cnt_ins;
						if (frame_end) begin
							x_q <= '0;
							y_q <= '0;
							if (cnt_ins != '0) begin
								state_q <= ST_EMIT;
							end
						end else if (row_end) begin
							x_q <= '0;
							y_q <= y_q + CW'(1);
						end else begin
							x_q <= x_q + CW'(1);
						end
					end
				end
				ST_EMIT: begin
					if (m_acc) begin
						cnt_q <= cnt_q - KW'(1);
						if (m_tlast) begin
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	logic [MAX_POINTS-1:0] vld_vec;
	for (genvar gv = 0; gv < MAX_POINTS; gv++) begin : g_vld
		assign vld_vec[gv] = vld[gv];
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output phases overlap");

	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == 32'(cnt_q))
		else $error("fill count and cell valid bits disagree");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_POINTS)
		else $error("fill count beyond chain length");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && m_tlast |=> s_tready && !vld_vec[0])
		else $error("chain not empty after the final point");

	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({op.ins, op.rep, op.pop}))
		else $error("conflicting chain commands");

endmodule

// ----- verif/d8_pour_point_top_n_tb.sv -----
// Self-checking testbench for d8_pour_point_top_n: streams raster frames into the block,
// predicts the kept pour points of every frame and checks each emitted point in order.
// Depends on d8pp_pkg and the RTL of the block.
module d8_pour_point_top_n_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FLOW_W    = d8pp_pkg::FLOW_W;
	localparam int DIR_W     = d8pp_pkg::DIR_W;
	localparam int COORD_W   = d8pp_pkg::COORD_W;
	localparam int CFG_W     = d8pp_pkg::CFG_W;
	localparam int CFG_IDX_W = d8pp_pkg::CFG_IDX_W;
	localparam int NPTS_W    = d8pp_pkg::NPTS_W;
	localparam int S_TDATA_W = d8pp_pkg::S_TDATA_W;
	localparam int M_TDATA_W = d8pp_pkg::M_TDATA_W;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int RANDOM_CELLS  = 136;
	localparam int DIM_LIMIT     = d8pp_pkg::MAX_DIM_DEF;
	localparam int KEEP_LIMIT    = d8pp_pkg::MAX_POINTS_DEF;

	// direction codes of the flow_dir field
	localparam logic [DIR_W-1:0] DIR_E        = 4'd0;
	localparam logic [DIR_W-1:0] DIR_N        = 4'd6;
	localparam logic [DIR_W-1:0] DIR_NE       = 4'd7;
	localparam logic [DIR_W-1:0] DIR_NONE     = 4'hF;
	localparam logic [DIR_W-1:0] DIR_NONE_LOW = 4'h8;  // -8, still means no direction

	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

	// column and row steps per direction code E, SE, S, SW, W, NW, N, NE
	localparam int COL_STEP [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
	localparam int ROW_STEP [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               is_last;
	} pour_point_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [3:0] flow_dir, [35:4] flow_value, [39:36] zero
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [11:0] point_x, [23:12] point_y
	logic                 m_tlast;

	// shadow of the block's registers and state
	logic [CFG_W-1:0]  cur_width;
	logic [CFG_W-1:0]  cur_height;
	logic [NPTS_W-1:0] cur_npts;
	int                col_pos;
	int                row_pos;
	d8pp_pkg::entry_t  kept_list [$];

	pour_point_t pending_points [$];

	int burst_left;
	int gap_max;
	int rx_mode;
	int rx_phase;
	int hold_left;
	int cycle_count;
	int error_count;
	int cells_sent;
	int frames_done;
	int points_due;
	int points_checked;

	d8_pour_point_top_n dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: a long hold-off on request, otherwise a stall pattern per mode
	always @(posedge clk) begin
		rx_phase++;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ((rx_phase % 7) >= 3);
			endcase
		end
	end

	// compare every output transaction with the oldest predicted point
	always @(posedge clk) begin
		pour_point_t exp_pt;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected pour point x=%0d y=%0d last=%0b",
					m_tdata[11:0], m_tdata[23:12], m_tlast);
				error_count++;
			end else begin
				exp_pt = pending_points.pop_front();
				points_checked++;
				if (m_tdata[11:0] !== exp_pt.x) begin
					$error("point_x mismatch: expected %0d, got %0d", exp_pt.x, m_tdata[11:0]);
					error_count++;
				end
				if (m_tdata[23:12] !== exp_pt.y) begin
					$error("point_y mismatch: expected %0d, got %0d", exp_pt.y, m_tdata[23:12]);
					error_count++;
				end
				if (m_tlast !== exp_pt.is_last) begin
					$error("last_point mismatch: expected %0b, got %0b", exp_pt.is_last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// judge one accepted cell: pour point test, top-n insertion, frame end output
	function automatic void judge_cell(input logic [DIR_W-1:0] dir,
		input logic [FLOW_W-1:0] flow);
		int w, h, lim, nx, ny, pos;
		bit pour, take, row_end;
		d8pp_pkg::entry_t ent;
		pour_point_t pt;
		w = (cur_width == 0) ? 1 : ((cur_width > DIM_LIMIT) ? DIM_LIMIT : int'(cur_width));
		h = (cur_height == 0) ? 1 : ((cur_height > DIM_LIMIT) ? DIM_LIMIT : int'(cur_height));
		lim = (cur_npts > KEEP_LIMIT) ? KEEP_LIMIT : int'(cur_npts);
		if (dir[DIR_W-1]) begin
			pour = 1'b1;
		end else begin
			nx = col_pos + COL_STEP[dir[2:0]];
			ny = row_pos + ROW_STEP[dir[2:0]];
			pour = (nx < 0) || (ny < 0) || (nx >= w) || (ny >= h);
		end
		// a full list (or one over a lowered limit) takes only a strictly larger flow
		take = pour && (lim > 0) && (kept_list.size() < lim || flow > kept_list[0].flow);
		if (take) begin
			if (kept_list.size() >= lim)
				void'(kept_list.pop_front());
			ent.flow = flow;
			ent.col = col_pos[COORD_W-1:0];
			ent.row = row_pos[COORD_W-1:0];
			pos = 0;
			while (pos < kept_list.size() && kept_list[pos].flow <= flow)
				pos++;
			kept_list.insert(pos, ent);
		end
		row_end = (col_pos >= w - 1);
		if (row_end && row_pos >= h - 1) begin
			foreach (kept_list[i]) begin
				pt.x = kept_list[i].col;
				pt.y = kept_list[i].row;
				pt.is_last = (i == kept_list.size() - 1);
				pending_points.insert(pending_points.size(), pt);
				points_due++;
			end
			kept_list.delete();
			col_pos = 0;
			row_pos = 0;
			frames_done++;
		end else if (row_end) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
	endfunction

	task automatic send_cell(input logic [DIR_W-1:0] dir, input logic [FLOW_W-1:0] flow);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, flow, dir};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		cells_sent++;
		judge_cell(dir, flow);
	endtask

	// sender pauses until every predicted point is out, then lets the block settle
	task automatic drain_points();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input d8pp_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			d8pp_pkg::REG_MAP_WIDTH:  cur_width = val;
			d8pp_pkg::REG_MAP_HEIGHT: cur_height = val;
			default:                  cur_npts = val[NPTS_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input logic [CFG_W-1:0] n);
		write_reg(d8pp_pkg::REG_MAP_WIDTH, w);
		write_reg(d8pp_pkg::REG_MAP_HEIGHT, h);
		write_reg(d8pp_pkg::REG_N_POINTS, n);
	endtask

	function automatic logic [FLOW_W-1:0] pick_flow();
		case ($urandom_range(0, 3))
			0, 1: return $urandom();
			2: return $urandom_range(0, 7);   // small values give many ties
			default: return $urandom_range(0, 1) ? FLOW_MAX : '0;
		endcase
	endfunction

	// reset geometry, then shrink it under a partly sent row so that it ends early
	task automatic test_defaults_then_shrink();
		send_cell(DIR_N, 32'd100);
		send_cell(DIR_NE, 32'd100);
		send_cell(DIR_NONE, 32'd7);
		drain_points();
		write_reg(d8pp_pkg::REG_MAP_WIDTH, 13'd3);
		write_reg(d8pp_pkg::REG_MAP_HEIGHT, 13'd1);
		send_cell(DIR_NONE_LOW, FLOW_MAX);
		drain_points();
	endtask

	task automatic test_directions();
		logic [FLOW_W-1:0] flow;
		set_frame(13'd4, 13'd4, 13'd16);
		for (int i = 0; i < 16; i++) begin
			flow = (i == 15) ? FLOW_MAX : FLOW_W'((i % 4) * 7);
			send_cell(DIR_W'(i), flow);
		end
		drain_points();
	endtask

	task automatic test_zero_points();
		set_frame(13'd2, 13'd1, 13'd0);
		send_cell(DIR_NONE, FLOW_MAX);
		send_cell(DIR_E, FLOW_MAX);
		drain_points();
	endtask

	// equal flows are refused by a full list, a larger one evicts the oldest smallest
	task automatic test_full_list();
		set_frame(13'd5, 13'd1, 13'd2);
		send_cell(DIR_NONE, 32'd5);
		send_cell(DIR_NONE, 32'd5);
		send_cell(DIR_NONE, 32'd3);
		send_cell(DIR_NONE, 32'd5);
		send_cell(DIR_NONE, 32'd9);
		drain_points();
	endtask

	task automatic test_lower_mid_frame();
		set_frame(13'd6, 13'd1, 13'd4);
		send_cell(DIR_NONE, 32'd10);
		send_cell(DIR_NONE, 32'd20);
		send_cell(DIR_NONE, 32'd30);
		drain_points();
		write_reg(d8pp_pkg::REG_N_POINTS, 13'd1);
		send_cell(DIR_NONE, 32'd15);
		send_cell(DIR_NONE, 32'd5);
		send_cell(DIR_NONE, 32'd40);
		drain_points();
	endtask

	// zero geometry clamps to one cell per frame; an oversized point count saturates
	task automatic test_zero_geometry();
		set_frame(13'd0, 13'd0, 13'd31);
		repeat (3) send_cell(DIR_W'($urandom_range(0, 15)), pick_flow());
		drain_points();
	endtask

	// long receiver hold-off while whole frames wait behind the output phase
	task automatic test_backpressure();
		set_frame(13'd4, 13'd4, 13'd16);
		rx_mode = 0;
		hold_left = 300;
		repeat (3 * 16) send_cell(DIR_NONE, pick_flow());
		drain_points();
	endtask

	task automatic test_random();
		int w, h, start_cells;
		w = 4;
		h = 4;
		start_cells = cells_sent;
		while (cells_sent - start_cells < RANDOM_CELLS) begin
			if ($urandom_range(0, 2) == 0) begin
				drain_points();
				w = $urandom_range(0, 8);
				h = $urandom_range(0, 5);
				set_frame(CFG_W'(w), CFG_W'(h),
					($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(17, 31))
						: CFG_W'($urandom_range(0, 16)));
				rx_mode = $urandom_range(0, 2);
				gap_max = $urandom_range(0, 1) ? 0 : 6;
			end
			repeat (((w == 0) ? 1 : w) * ((h == 0) ? 1 : h))
				send_cell(DIR_W'($urandom_range(0, 15)), pick_flow());
		end
		drain_points();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = d8pp_pkg::REG_MAP_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cur_width = CFG_W'(d8pp_pkg::DIM_RESET);
		cur_height = CFG_W'(d8pp_pkg::DIM_RESET);
		cur_npts = NPTS_W'(d8pp_pkg::NPTS_RESET);
		col_pos = 0;
		row_pos = 0;
		burst_left = 0;
		gap_max = 6;
		rx_mode = 1;
		hold_left = 0;
		error_count = 0;
		cells_sent = 0;
		frames_done = 0;
		points_due = 0;
		points_checked = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_then_shrink();
		test_directions();
		test_zero_points();
		test_full_list();
		test_lower_mid_frame();
		test_zero_geometry();
		test_backpressure();
		test_random();

		if (pending_points.size() != 0) begin
			$error("%0d predicted pour points never emitted", pending_points.size());
			error_count++;
		end
		$display("Run covered %0d cells in %0d frames; %0d pour points checked.",
			cells_sent, frames_done, points_checked);
		$display("Included: all direction codes, full and lowered lists, %s",
			"zero geometry, a shrunk frame, long output stall.");
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
